// ===== rtl/aik_pkg.sv =====
// Shared types, codes and constants of the two-link arm solver.
// Used by the CORDIC, datapath, sequencer and top modules; depends on nothing.
package aik_pkg;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic        [5:0]  step_count;
    } t_in_req;

    typedef struct packed {
        logic signed [19:0] upper_angle;
        logic signed [19:0] fore_angle;
        logic               is_last;
    } t_out_res;

    localparam logic [1:0] CFG_BASE_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_UPPER_ARM   = 2'd1;
    localparam logic [1:0] CFG_FORE_ARM    = 2'd2;
    localparam logic [1:0] CFG_MOVE_THR    = 2'd3;

    localparam logic [4:0] CORDIC_LAST = 5'd22;
    localparam logic signed [26:0] DEG90_Q16  = 27'sd5898240;
    localparam logic signed [26:0] DEG180_Q16 = 27'sd11796480;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP,
        S_SQ_AREA, S_SQ_AREA_W, S_SQ_REACH, S_SQ_REACH_W,
        S_COR_INNER, S_COR_INNER_W, S_COR_SIDE, S_COR_SIDE_W,
        S_COR_ELEV, S_COR_ELEV_W,
        S_ANGLES, S_DIV, S_DIV_W, S_STEP, S_FIRST, S_LAST
    } t_ctrl_state;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_TX, MUL_TY, MUL_HGT, MUL_SPAN, MUL_GAP,
        MUL_LA, MUL_LB, MUL_LALB, MUL_DEN, MUL_CNUM
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_NONE, ST_REACH, ST_REACH_ADD, ST_DIST, ST_SPAN2, ST_GAP2,
        ST_LA2, ST_LB2, ST_DEN, ST_RAD, ST_RAD_SUB
    } t_st_sel;

    typedef enum logic {SQ_AREA, SQ_REACH} t_sq_sel;

    typedef enum logic [1:0] {COR_INNER, COR_SIDE, COR_ELEV} t_cor_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        t_st_sel  st_sel;
        logic     cnum_calc;
        logic     sq_start;
        logic     sq_store;
        t_sq_sel  sq_sel;
        logic     cor_start;
        logic     cor_store;
        t_cor_sel cor_sel;
        logic     angles;
        logic     div_start;
        logic     emit_step;
        logic     emit_first;
        logic     emit_last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_range;
        logic moved;
        logic sq_done;
        logic cor_done;
        logic div_done;
        logic out_free;
        logic last_step;
    } t_dp_status;

    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/aik_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing.
module aik_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] cand, trial;

    assign cand  = {r_rem[32:0], r_val[63:62]};
    assign trial = {1'b0, r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == 5'd31) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= 5'd0;
            r_val  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_val <= {r_val[61:0], 2'b00};
            if (cand >= trial) begin
                r_rem  <= cand - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= cand;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

// ===== rtl/aik_cordic.sv =====
// Vectoring CORDIC for the angle of a first-quadrant vector, degrees Q.16.
// Normalizes by doubling, then runs 23 rotations. Depends on aik_pkg.
module aik_cordic import aik_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [40:0]        i_a,
    input  logic [40:0]        i_b,
    output logic               o_busy,
    output logic signed [24:0] o_angle
);
    logic               r_busy, n_busy;
    logic               r_norm;
    logic [4:0]         r_idx;
    logic signed [43:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic signed [43:0] dx, dy;
    logic signed [24:0] at;
    logic               below_lim;

    assign dx        = r_y >>> r_idx;
    assign dy        = r_x >>> r_idx;
    assign at        = $signed({3'b000, atan_q16(r_idx)});
    assign below_lim = (r_x[43:40] == 4'd0) && (r_y[43:40] == 4'd0);

    always_comb begin
        n_busy = r_busy;
        if (i_start) begin
            n_busy = (i_a != '0) || (i_b != '0);
        end else if (r_busy && !r_norm && r_idx == CORDIC_LAST) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed({3'b000, i_a});
            r_y    <= $signed({3'b000, i_b});
            r_z    <= '0;
            r_idx  <= '0;
            r_norm <= 1'b1;
        end else if (r_busy && r_norm) begin
            if (below_lim) begin
                r_x <= r_x <<< 1;
                r_y <= r_y <<< 1;
            end else begin
                r_norm <= 1'b0;
            end
        end else if (r_busy) begin
            r_idx <= r_idx + 5'd1;
            if (r_y >= 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_z;
endmodule

// ===== rtl/aik_div.sv =====
// Restoring divider of a 20-bit magnitude by a 6-bit step count, one bit per cycle.
// Depends on nothing.
module aik_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_dvd,
    input  logic [5:0]  i_dvs,
    output logic        o_busy,
    output logic [19:0] o_quo,
    output logic [5:0]  o_rem
);
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt;
    logic [19:0] r_val;
    logic [5:0]  r_rem;
    logic [5:0]  r_dvs;
    logic [6:0]  cand;

    assign cand = {r_rem, r_val[19]};

    always_comb begin
        n_busy = r_busy;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == 5'd19) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_val <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (cand >= {1'b0, r_dvs}) begin
                r_rem <= 6'(cand - {1'b0, r_dvs});
                r_val <= {r_val[18:0], 1'b1};
            end else begin
                r_rem <= cand[5:0];
                r_val <= {r_val[18:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_val;
    assign o_rem  = r_rem;
endmodule

// ===== rtl/aik_dpath.sv =====
// Datapath: registers, shared multiplier, square root, CORDIC and dividers,
// step interpolation and output register. Depends on aik_pkg and the units.
module aik_dpath import aik_pkg::*; #(
    parameter int MAX_STEPS = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_req    i_in_req,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_res   o_out_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_stat
);
    localparam logic [5:0] MAX_N = 6'(MAX_STEPS);

    logic [14:0] r_base, r_la, r_lb;
    logic [7:0]  r_thr;
    t_in_req     r_in;
    logic signed [15:0] r_last_x, r_last_y, r_last_z;
    logic signed [19:0] r_held_u, r_held_f;

    logic signed [63:0] r_prod;
    logic [31:0] r_reach2, r_span2, r_gap2, r_den, r_area;
    logic [33:0] r_dist2;
    logic [29:0] r_la2, r_lb2;
    logic [63:0] r_rad;
    logic signed [35:0] r_cnum;
    logic [23:0] r_rq8;
    logic signed [26:0] r_inner, r_side, r_elev;
    logic signed [19:0] r_up8, r_fo8;
    logic [5:0]  r_k;
    logic [19:0] r_qu, r_qf;
    logic [5:0]  r_ru, r_rf;
    logic        r_out_valid;
    t_out_res    r_out;

    // geometry
    logic signed [16:0] hgt, hgt_abs;
    logic [15:0] span;
    logic signed [15:0] gap;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [35:0] side_c;

    assign hgt     = $signed({r_in.target_z[15], r_in.target_z}) - $signed({2'b00, r_base});
    assign hgt_abs = hgt[16] ? -hgt : hgt;
    assign span    = {1'b0, r_la} + {1'b0, r_lb};
    assign gap     = $signed({1'b0, r_la}) - $signed({1'b0, r_lb});
    assign side_c  = $signed({6'd0, r_la2}) + $signed({2'b00, r_dist2})
                   - $signed({6'd0, r_lb2});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_sel)
            MUL_TX:   begin
                mul_a = {{18{r_in.target_x[15]}}, r_in.target_x}; mul_b = mul_a;
            end
            MUL_TY:   begin
                mul_a = {{18{r_in.target_y[15]}}, r_in.target_y}; mul_b = mul_a;
            end
            MUL_HGT:  begin mul_a = {{17{hgt[16]}}, hgt};  mul_b = mul_a; end
            MUL_SPAN: begin mul_a = {18'd0, span};         mul_b = mul_a; end
            MUL_GAP:  begin mul_a = {{18{gap[15]}}, gap};  mul_b = mul_a; end
            MUL_LA:   begin mul_a = {19'd0, r_la};         mul_b = mul_a; end
            MUL_LB:   begin mul_a = {19'd0, r_lb};         mul_b = mul_a; end
            MUL_LALB: begin mul_a = {19'd0, r_la};         mul_b = {19'd0, r_lb}; end
            MUL_DEN:  begin mul_a = {2'b00, r_den};        mul_b = mul_a; end
            MUL_CNUM: begin mul_a = r_cnum[33:0];          mul_b = mul_a; end
            default:  begin mul_a = '0;                    mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // configuration and input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 15'd0;
            r_la   <= 15'd1267;
            r_lb   <= 15'd2694;
            r_thr  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_HEIGHT: r_base <= i_cfg_data;
                CFG_UPPER_ARM:   r_la   <= i_cfg_data;
                CFG_FORE_ARM:    r_lb   <= i_cfg_data;
                CFG_MOVE_THR:    r_thr  <= i_cfg_data[7:0];
                default:         r_thr  <= r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_req;
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
        unique case (i_cmd.st_sel)
            ST_REACH:     r_reach2 <= r_prod[31:0];
            ST_REACH_ADD: r_reach2 <= r_reach2 + r_prod[31:0];
            ST_DIST:      r_dist2  <= {2'b00, r_reach2} + r_prod[33:0];
            ST_SPAN2:     r_span2  <= r_prod[31:0];
            ST_GAP2:      r_gap2   <= r_prod[31:0];
            ST_LA2:       r_la2    <= r_prod[29:0];
            ST_LB2:       r_lb2    <= r_prod[29:0];
            ST_DEN:       r_den    <= {r_prod[30:0], 1'b0};
            ST_RAD:       r_rad    <= r_prod;
            ST_RAD_SUB:   r_rad    <= r_rad - r_prod;
            default:      r_rad    <= r_rad;
        endcase
        if (i_cmd.cnum_calc) begin
            r_cnum <= $signed({6'd0, r_la2}) + $signed({6'd0, r_lb2})
                    - $signed({2'b00, r_dist2});
        end
    end

    // square root
    logic [63:0] sq_rad;
    logic        sq_busy;
    logic [31:0] sq_root;

    assign sq_rad = (i_cmd.sq_sel == SQ_AREA) ? r_rad : {16'd0, r_reach2, 16'd0};

    aik_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_rad   (sq_rad),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_store) begin
            if (i_cmd.sq_sel == SQ_AREA) begin
                r_area <= sq_root;
            end else begin
                r_rq8 <= sq_root[23:0];
            end
        end
    end

    // angles
    logic signed [35:0] cor_c, cor_cabs;
    logic [40:0]        cor_a, cor_b;
    logic               cor_busy;
    logic signed [24:0] cor_z;
    logic signed [26:0] cor_zx, arc;

    always_comb begin
        unique case (i_cmd.cor_sel)
            COR_INNER: begin cor_c = -r_cnum;                 cor_b = {9'd0, r_area}; end
            COR_SIDE:  begin cor_c = side_c;                  cor_b = {9'd0, r_area}; end
            default:   begin cor_c = $signed({12'd0, r_rq8}); cor_b = {17'd0, hgt_abs[15:0], 8'd0}; end
        endcase
    end

    assign cor_cabs = cor_c[35] ? -cor_c : cor_c;
    assign cor_a    = {6'd0, cor_cabs[34:0]};

    aik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cor_start),
        .i_a     (cor_a),
        .i_b     (cor_b),
        .o_busy  (cor_busy),
        .o_angle (cor_z)
    );

    assign cor_zx = {{2{cor_z[24]}}, cor_z};

    always_comb begin
        if (cor_c == '0 && cor_b == '0) begin
            arc = DEG90_Q16;
        end else if (!cor_c[35]) begin
            arc = cor_zx;
        end else begin
            arc = DEG180_Q16 - cor_zx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_store) begin
            unique case (i_cmd.cor_sel)
                COR_INNER: r_inner <= arc[26] ? '0 : arc;
                COR_SIDE:  r_side  <= arc;
                default:   r_elev  <= hgt[16] ? -cor_zx : cor_zx;
            endcase
        end
    end

    logic signed [26:0] fo_t, up_t;

    assign fo_t = 27'sd128 - (r_inner <<< 1);
    assign up_t = DEG90_Q16 - r_elev - r_side + 27'sd128;

    always_ff @(posedge i_clk) begin
        if (i_cmd.angles) begin
            r_fo8 <= 20'(fo_t >>> 8);
            r_up8 <= 20'(up_t >>> 8);
        end
    end

    // move test
    logic signed [16:0] ddx, ddy, ddz;
    logic [16:0] adx, ady, adz;
    logic        moved;

    assign ddx = $signed({r_in.target_x[15], r_in.target_x}) - $signed({r_last_x[15], r_last_x});
    assign ddy = $signed({r_in.target_y[15], r_in.target_y}) - $signed({r_last_y[15], r_last_y});
    assign ddz = $signed({r_in.target_z[15], r_in.target_z}) - $signed({r_last_z[15], r_last_z});
    assign adx = ddx[16] ? 17'(-ddx) : 17'(ddx);
    assign ady = ddy[16] ? 17'(-ddy) : 17'(ddy);
    assign adz = ddz[16] ? 17'(-ddz) : 17'(ddz);
    assign moved = (adx > {9'd0, r_thr}) || (ady > {9'd0, r_thr}) || (adz > {9'd0, r_thr});

    // interpolation
    logic [5:0]  n_one, n_eff;
    logic signed [20:0] du, df, du_abs, df_abs;
    logic        du_busy, df_busy;
    logic [19:0] quo_u, quo_f;
    logic [5:0]  rem_u, rem_f;

    assign n_one  = (r_in.step_count == 6'd0) ? 6'd1 : r_in.step_count;
    assign n_eff  = (n_one > MAX_N) ? MAX_N : n_one;
    assign du     = $signed({r_up8[19], r_up8}) - $signed({r_held_u[19], r_held_u});
    assign df     = $signed({r_fo8[19], r_fo8}) - $signed({r_held_f[19], r_held_f});
    assign du_abs = du[20] ? -du : du;
    assign df_abs = df[20] ? -df : df;

    aik_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (du_abs[19:0]),
        .i_dvs   (n_eff),
        .o_busy  (du_busy),
        .o_quo   (quo_u),
        .o_rem   (rem_u)
    );

    aik_div u_div_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (df_abs[19:0]),
        .i_dvs   (n_eff),
        .o_busy  (df_busy),
        .o_quo   (quo_f),
        .o_rem   (rem_f)
    );

    logic [6:0]  sum_ru, sum_rf;
    logic        wrap_u, wrap_f;
    logic [19:0] nq_u, nq_f;
    logic [5:0]  nr_u, nr_f;
    logic signed [20:0] off_u, off_f, val_u, val_f;

    assign sum_ru = {1'b0, r_ru} + {1'b0, rem_u};
    assign sum_rf = {1'b0, r_rf} + {1'b0, rem_f};
    assign wrap_u = sum_ru >= {1'b0, n_eff};
    assign wrap_f = sum_rf >= {1'b0, n_eff};
    assign nq_u   = r_qu + quo_u + {19'd0, wrap_u};
    assign nq_f   = r_qf + quo_f + {19'd0, wrap_f};
    assign nr_u   = wrap_u ? 6'(sum_ru - {1'b0, n_eff}) : sum_ru[5:0];
    assign nr_f   = wrap_f ? 6'(sum_rf - {1'b0, n_eff}) : sum_rf[5:0];
    assign off_u  = du[20] ? -$signed({1'b0, nq_u}) : $signed({1'b0, nq_u});
    assign off_f  = df[20] ? -$signed({1'b0, nq_f}) : $signed({1'b0, nq_f});
    assign val_u  = $signed({r_held_u[19], r_held_u}) + off_u;
    assign val_f  = $signed({r_held_f[19], r_held_f}) + off_f;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_k  <= '0;
            r_qu <= '0;
            r_qf <= '0;
            r_ru <= '0;
            r_rf <= '0;
        end else if (i_cmd.emit_step) begin
            r_k  <= r_k + 6'd1;
            r_qu <= nq_u;
            r_qf <= nq_f;
            r_ru <= nr_u;
            r_rf <= nr_f;
        end
    end

    // held state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
            r_last_z <= '0;
            r_held_u <= '0;
            r_held_f <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_last) begin
                r_last_x <= r_in.target_x;
                r_last_y <= r_in.target_y;
                r_last_z <= r_in.target_z;
                r_held_u <= r_up8;
                r_held_f <= r_fo8;
            end
            if (i_cmd.emit_step || i_cmd.emit_first || i_cmd.emit_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step) begin
            r_out.upper_angle <= val_u[19:0];
            r_out.fore_angle  <= val_f[19:0];
            r_out.is_last     <= 1'b0;
        end else if (i_cmd.emit_first || i_cmd.emit_last) begin
            r_out.upper_angle <= r_up8;
            r_out.fore_angle  <= r_fo8;
            r_out.is_last     <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    assign o_stat.out_range = (r_dist2 > {2'b00, r_span2}) || (r_dist2 < {2'b00, r_gap2});
    assign o_stat.moved     = moved;
    assign o_stat.sq_done   = !sq_busy;
    assign o_stat.cor_done  = !cor_busy;
    assign o_stat.div_done  = !du_busy && !df_busy;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.last_step = ({1'b0, r_k} + 7'd1) == {1'b0, n_eff};
endmodule

// ===== rtl/aik_ctrl.sv =====
// Sequencer of the solver: issues multiply, root, angle, divide and emit commands.
// Depends on aik_pkg.
module aik_ctrl import aik_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_stat,
    output t_ctrl_cmd  o_cmd
);
    t_ctrl_state r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = (r_state == S_PREP) ? r_cnt + 4'd1 : 4'd0;
        unique case (r_state)
            S_IDLE:        if (i_in_valid) n_state = S_PREP;
            S_PREP: begin
                if (r_cnt == 4'd8 && i_stat.out_range) begin
                    n_state = S_IDLE;
                end else if (r_cnt == 4'd11) begin
                    n_state = S_SQ_AREA;
                end
            end
            S_SQ_AREA:     n_state = S_SQ_AREA_W;
            S_SQ_AREA_W:   if (i_stat.sq_done) n_state = S_SQ_REACH;
            S_SQ_REACH:    n_state = S_SQ_REACH_W;
            S_SQ_REACH_W:  if (i_stat.sq_done) n_state = S_COR_INNER;
            S_COR_INNER:   n_state = S_COR_INNER_W;
            S_COR_INNER_W: if (i_stat.cor_done) n_state = S_COR_SIDE;
            S_COR_SIDE:    n_state = S_COR_SIDE_W;
            S_COR_SIDE_W:  if (i_stat.cor_done) n_state = S_COR_ELEV;
            S_COR_ELEV:    n_state = S_COR_ELEV_W;
            S_COR_ELEV_W:  if (i_stat.cor_done) n_state = S_ANGLES;
            S_ANGLES:      n_state = i_stat.moved ? S_DIV : S_FIRST;
            S_DIV:         n_state = S_DIV_W;
            S_DIV_W:       if (i_stat.div_done) n_state = S_STEP;
            S_STEP:        if (i_stat.out_free && i_stat.last_step) n_state = S_LAST;
            S_FIRST:       if (i_stat.out_free) n_state = S_LAST;
            S_LAST:        if (i_stat.out_free) n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.mul_sel    = MUL_NONE;
        o_cmd.st_sel     = ST_NONE;
        o_cmd.sq_sel     = SQ_AREA;
        o_cmd.cor_sel    = COR_INNER;
        o_in_ready       = (r_state == S_IDLE);
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_PREP: begin
                unique case (r_cnt)
                    4'd0:  o_cmd.mul_sel = MUL_TX;
                    4'd1:  begin o_cmd.mul_sel = MUL_TY;   o_cmd.st_sel = ST_REACH;     end
                    4'd2:  begin o_cmd.mul_sel = MUL_HGT;  o_cmd.st_sel = ST_REACH_ADD; end
                    4'd3:  begin o_cmd.mul_sel = MUL_SPAN; o_cmd.st_sel = ST_DIST;      end
                    4'd4:  begin o_cmd.mul_sel = MUL_GAP;  o_cmd.st_sel = ST_SPAN2;     end
                    4'd5:  begin o_cmd.mul_sel = MUL_LA;   o_cmd.st_sel = ST_GAP2;      end
                    4'd6:  begin o_cmd.mul_sel = MUL_LB;   o_cmd.st_sel = ST_LA2;       end
                    4'd7:  begin o_cmd.mul_sel = MUL_LALB; o_cmd.st_sel = ST_LB2;       end
                    4'd8:  begin o_cmd.st_sel = ST_DEN;    o_cmd.cnum_calc = 1'b1;      end
                    4'd9:  o_cmd.mul_sel = MUL_DEN;
                    4'd10: begin o_cmd.mul_sel = MUL_CNUM; o_cmd.st_sel = ST_RAD;       end
                    4'd11: o_cmd.st_sel = ST_RAD_SUB;
                    default: o_cmd.st_sel = ST_NONE;
                endcase
            end
            S_SQ_AREA:     o_cmd.sq_start = 1'b1;
            S_SQ_AREA_W:   o_cmd.sq_store = i_stat.sq_done;
            S_SQ_REACH:    begin o_cmd.sq_sel = SQ_REACH; o_cmd.sq_start = 1'b1; end
            S_SQ_REACH_W:  begin o_cmd.sq_sel = SQ_REACH; o_cmd.sq_store = i_stat.sq_done; end
            S_COR_INNER:   o_cmd.cor_start = 1'b1;
            S_COR_INNER_W: o_cmd.cor_store = i_stat.cor_done;
            S_COR_SIDE:    begin o_cmd.cor_sel = COR_SIDE; o_cmd.cor_start = 1'b1; end
            S_COR_SIDE_W:  begin o_cmd.cor_sel = COR_SIDE; o_cmd.cor_store = i_stat.cor_done; end
            S_COR_ELEV:    begin o_cmd.cor_sel = COR_ELEV; o_cmd.cor_start = 1'b1; end
            S_COR_ELEV_W:  begin o_cmd.cor_sel = COR_ELEV; o_cmd.cor_store = i_stat.cor_done; end
            S_ANGLES:      o_cmd.angles = 1'b1;
            S_DIV:         o_cmd.div_start = 1'b1;
            S_STEP:        o_cmd.emit_step = i_stat.out_free;
            S_FIRST:       o_cmd.emit_first = i_stat.out_free;
            S_LAST:        o_cmd.emit_last = i_stat.out_free;
            default:       o_cmd.load = o_cmd.load;
        endcase
    end
endmodule

// ===== rtl/arm_ik_interpolator.sv =====
// Two-link planar arm solver with step interpolation: top level.
// Joins the sequencer aik_ctrl and the datapath aik_dpath; uses aik_pkg.
//
// A request carries a target point and a step count. The block takes one
// request at a time: shared-multiplier setup (a target outside the
// reachable annulus is dropped there), two square roots, then three
// CORDIC runs, each normalizing by up to 40 doublings before its rotations,
// a step to form the angles, and for a moved target a divide. Then one
// result is delivered per cycle while the output is not stalled: step_count
// steps (at least one, at most MAX_STEPS) and a final repeat, or two results
// when the target did not move. The sequential root and CORDIC loops set the
// pace.
module arm_ik_interpolator import aik_pkg::*; #(
    parameter int MAX_STEPS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_res    o_out_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);
    t_ctrl_cmd  cmd;
    t_dp_status stat;

    aik_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    aik_dpath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );
endmodule
